// ===== src/kcvf_pkg.sv =====
// Package for the constant-velocity Kalman filter unit.
// Holds data widths, fixed-point constants and register indexes; no dependencies.
package kcvf_pkg;
  localparam int DW = 32;
  localparam int FB = 16;
  localparam int MAX_H = 16;
  localparam int HW = 5;
  localparam int CFG_W = 31;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE = DW'(1) <<< FB;

  localparam logic [1:0] REG_Q_POS = 2'd0;
  localparam logic [1:0] REG_Q_VEL = 2'd1;
  localparam logic [1:0] REG_R_MEAS = 2'd2;
  localparam logic [1:0] REG_HORIZON = 2'd3;

  typedef logic signed [DW-1:0] data_t;

  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) sat_add = s[DW] ? VMIN : VMAX;
    else sat_add = s[DW-1:0];
  endfunction

  function automatic data_t sat_sub(input data_t a, input data_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) sat_sub = s[DW] ? VMIN : VMAX;
    else sat_sub = s[DW-1:0];
  endfunction
endpackage

// ===== src/kcvf_mul.sv =====
// Registered fixed-point multiplier: round to nearest, ties away, saturate.
// Depends on kcvf_pkg.
module kcvf_mul (
  input  logic           clk,
  input  kcvf_pkg::data_t a,
  input  kcvf_pkg::data_t b,
  output kcvf_pkg::data_t p
);
  logic neg;
  logic [kcvf_pkg::DW-1:0] ua, ub;
  logic [2*kcvf_pkg::DW-1:0] prod, rnd;
  logic [2*kcvf_pkg::DW-1:0] sh;
  logic [kcvf_pkg::DW-1:0] prod_neg_r;
  logic [2*kcvf_pkg::DW-1:0] prod_r;
  logic neg_r;

  always_comb begin
    neg = a[kcvf_pkg::DW-1] ^ b[kcvf_pkg::DW-1];
    ua = a[kcvf_pkg::DW-1] ? -a : a;
    ub = b[kcvf_pkg::DW-1] ? -b : b;
    prod = ua * ub;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    neg_r <= neg;
  end

  always_comb begin
    rnd = prod_r + ((2*kcvf_pkg::DW)'(1) << (kcvf_pkg::FB-1));
    sh = rnd >> kcvf_pkg::FB;
    prod_neg_r = '0;
    if (neg_r) begin
      if (sh > (2*kcvf_pkg::DW)'({1'b1, {(kcvf_pkg::DW-1){1'b0}}})) p = kcvf_pkg::VMIN;
      else begin
        prod_neg_r = sh[kcvf_pkg::DW-1:0];
        p = -prod_neg_r;
      end
    end else begin
      if (sh > (2*kcvf_pkg::DW)'(kcvf_pkg::VMAX)) p = kcvf_pkg::VMAX;
      else p = sh[kcvf_pkg::DW-1:0];
    end
  end
endmodule

// ===== src/kcvf_div.sv =====
// Restoring serial divider: (num << FB) / den, truncated, saturated; one bit a cycle.
// Depends on kcvf_pkg.
module kcvf_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  kcvf_pkg::data_t num,
  input  kcvf_pkg::data_t den,
  output logic            done,
  output kcvf_pkg::data_t quo
);
  localparam int NB = kcvf_pkg::DW + kcvf_pkg::FB;
  localparam int CW = $clog2(NB + 1);
  logic [NB-1:0] dividend;
  logic [kcvf_pkg::DW:0] rem;
  logic [NB-1:0] q;
  logic [kcvf_pkg::DW-1:0] d;
  logic neg, busy;
  logic [CW-1:0] cnt;
  logic [kcvf_pkg::DW:0] trial;
  logic [kcvf_pkg::DW-1:0] qn;

  always_comb begin
    trial = {rem[kcvf_pkg::DW-1:0], dividend[NB-1]};
    qn = q[kcvf_pkg::DW-1:0];
    if (neg) begin
      if (q > NB'({1'b1, {(kcvf_pkg::DW-1){1'b0}}})) quo = kcvf_pkg::VMIN;
      else quo = -qn;
    end else begin
      if (q > NB'(kcvf_pkg::VMAX)) quo = kcvf_pkg::VMAX;
      else quo = qn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NB);
        neg <= num[kcvf_pkg::DW-1];
        dividend <= {(num[kcvf_pkg::DW-1] ? -num : num), {kcvf_pkg::FB{1'b0}}};
        d <= den;
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        dividend <= dividend << 1;
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q <= {q[NB-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NB-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/kalman_constant_velocity_filter_unit.sv =====
// Constant-velocity Kalman filter unit: sequencer around one multiplier and one divider.
// An accepted word passes through predict, two serial divides, six multiplies and the output
// load to its filtered estimate; the divides are skipped when S is not positive.
// No new word is taken until the last word and its extrapolations are out, later under out_stall.
// Synchronous reset restores the register defaults and the unseeded identity state.
// Depends on kcvf_pkg, kcvf_mul, kcvf_div.
module kalman_constant_velocity_filter_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [kcvf_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         measurement,
  input  logic                       last_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         value,
  output logic                       kind,
  output logic                       run_end
);
  typedef enum logic [3:0] {
    S_IDLE, S_PRED, S_DIV0, S_DIV1, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_OUT, S_EXT
  } state_t;
  state_t state;

  logic [15:0] q_pos, q_vel;
  logic [30:0] r_meas;
  logic [kcvf_pkg::HW-1:0] horizon;
  kcvf_pkg::data_t pos_est, vel_est, cov_pp, cov_pv, cov_vp, cov_vv;
  kcvf_pkg::data_t xp, p00, p01, p10, p11, s, k0, k1, y, fp;
  logic seeded, last_r, mphase;
  logic [kcvf_pkg::HW-1:0] hcnt;
  kcvf_pkg::data_t ma, mb, mp, dnum, dq;
  logic dstart, ddone;
  kcvf_pkg::data_t z, pp0, pv0, vp0, vv0, ps0, vs0;
  logic [kcvf_pkg::DW+2:0] p00_sum;
  kcvf_pkg::data_t p00_pred;

  kcvf_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
  kcvf_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(s),
                  .done(ddone), .quo(dq));

  assign in_stall = (state != S_IDLE);
  assign z = measurement;

  always_comb begin
    unique case (state)
      S_M0: begin ma = k0; mb = y; end
      S_M1: begin ma = k1; mb = y; end
      S_M2: begin ma = kcvf_pkg::sat_sub(kcvf_pkg::ONE, k0); mb = p00; end
      S_M3: begin ma = kcvf_pkg::sat_sub(kcvf_pkg::ONE, k0); mb = p01; end
      S_M4: begin ma = k1; mb = p00; end
      S_M5: begin ma = k1; mb = p01; end
      default: begin ma = '0; mb = '0; end
    endcase
    dnum = (state == S_DIV1) ? p10 : p00;
    dstart = ((state == S_DIV0) || (state == S_DIV1)) && !mphase;
    if (seeded) begin
      ps0 = pos_est; vs0 = vel_est; pp0 = cov_pp; pv0 = cov_pv;
      vp0 = cov_vp; vv0 = cov_vv;
    end else begin
      ps0 = z; vs0 = '0; pp0 = kcvf_pkg::ONE; pv0 = '0; vp0 = '0;
      vv0 = kcvf_pkg::ONE;
    end
    // full-width sum, saturated once
    p00_sum = {{3{pp0[kcvf_pkg::DW-1]}}, pp0} + {{3{pv0[kcvf_pkg::DW-1]}}, pv0} +
              {{3{vp0[kcvf_pkg::DW-1]}}, vp0} + {{3{vv0[kcvf_pkg::DW-1]}}, vv0} +
              {19'd0, q_pos};
    if (p00_sum[kcvf_pkg::DW+2:kcvf_pkg::DW-1] == '0 ||
        p00_sum[kcvf_pkg::DW+2:kcvf_pkg::DW-1] == '1)
      p00_pred = p00_sum[kcvf_pkg::DW-1:0];
    else
      p00_pred = p00_sum[kcvf_pkg::DW+2] ? kcvf_pkg::VMIN : kcvf_pkg::VMAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      q_pos <= 16'd655; q_vel <= 16'd655; r_meas <= 31'd6554;
      horizon <= kcvf_pkg::HW'(10);
      pos_est <= '0; vel_est <= '0; cov_pp <= kcvf_pkg::ONE; cov_pv <= '0;
      cov_vp <= '0; cov_vv <= kcvf_pkg::ONE;
      seeded <= 1'b0;
      out_valid <= 1'b0;
      mphase <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kcvf_pkg::REG_Q_POS: q_pos <= cfg_data[15:0];
          kcvf_pkg::REG_Q_VEL: q_vel <= cfg_data[15:0];
          kcvf_pkg::REG_R_MEAS: r_meas <= cfg_data[30:0];
          kcvf_pkg::REG_HORIZON: horizon <= cfg_data[kcvf_pkg::HW-1:0];
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          last_r <= last_sample;
          xp <= kcvf_pkg::sat_add(ps0, vs0);
          vel_est <= vs0;
          p00 <= p00_pred;
          p01 <= kcvf_pkg::sat_add(pv0, vv0);
          p10 <= kcvf_pkg::sat_add(vp0, vv0);
          p11 <= kcvf_pkg::sat_add(vv0, {16'd0, q_vel});
          y <= z;
          seeded <= 1'b1;
          state <= S_PRED;
        end
        S_PRED: begin
          s <= kcvf_pkg::sat_add(p00, {1'b0, r_meas});
          y <= kcvf_pkg::sat_sub(y, xp);
          state <= S_DIV0;
        end
        S_DIV0: begin
          if (s[31] || s == '0) begin
            k0 <= '0; k1 <= '0; state <= S_M0;
          end else if (!mphase) mphase <= 1'b1;
          else if (ddone) begin
            k0 <= dq; mphase <= 1'b0; state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (!mphase) mphase <= 1'b1;
          else if (ddone) begin
            k1 <= dq; mphase <= 1'b0; state <= S_M0;
          end
        end
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5: begin
          mphase <= !mphase;
          if (mphase) begin
            unique case (state)
              S_M0: begin pos_est <= kcvf_pkg::sat_add(xp, mp); state <= S_M1; end
              S_M1: begin vel_est <= kcvf_pkg::sat_add(vel_est, mp); state <= S_M2; end
              S_M2: begin cov_pp <= mp; state <= S_M3; end
              S_M3: begin cov_pv <= mp; state <= S_M4; end
              S_M4: begin cov_vp <= kcvf_pkg::sat_sub(p10, mp); state <= S_M5; end
              default: begin
                cov_vv <= kcvf_pkg::sat_sub(p11, mp);
                if (!last_r) hcnt <= '0;
                else if (horizon > kcvf_pkg::HW'(kcvf_pkg::MAX_H))
                  hcnt <= kcvf_pkg::HW'(kcvf_pkg::MAX_H);
                else hcnt <= horizon;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          value <= pos_est; kind <= 1'b0; run_end <= (hcnt == '0);
          fp <= pos_est;
          out_valid <= 1'b1;
          state <= S_EXT;
        end
        default: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            if (hcnt == '0) begin
              if (last_r) seeded <= 1'b0;
              state <= S_IDLE;
            end else begin
              value <= kcvf_pkg::sat_add(fp, vel_est);
              fp <= kcvf_pkg::sat_add(fp, vel_est);
              kind <= 1'b1;
              run_end <= (hcnt == kcvf_pkg::HW'(1));
              hcnt <= hcnt - kcvf_pkg::HW'(1);
              out_valid <= 1'b1;
            end
          end
        end
      endcase
    end
  end
endmodule

// ===== sim/kalman_constant_velocity_filter_unit_tb.sv =====
// Testbench for kalman_constant_velocity_filter_unit: random and directed measurement series
// checked word by word against a fixed-point filter predictor held in a scoreboard class.
// Depends on kcvf_pkg and the filter unit RTL.
module kalman_constant_velocity_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint UNIT = 64'sd65536;

  typedef struct {
    logic signed [31:0] value;
    logic               kind;
    logic               run_end;
  } estimate_t;

  class filter_scoreboard;
    longint q_pos, q_vel, r_meas, horizon;
    longint pos, vel, cpp, cpv, cvp, cvv;
    bit seeded;
    estimate_t pending[$];
    int errors, words, series;

    function new();
      q_pos = 655; q_vel = 655; r_meas = 6554; horizon = 10;
      pos = 0; vel = 0; cpp = UNIT; cpv = 0; cvp = 0; cvv = UNIT;
      seeded = 0; errors = 0; words = 0; series = 0;
    endfunction

    function longint clip(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
    endfunction

    // rounded Q16.16 product, ties away from zero
    function longint fx_mul(longint a, longint b);
      logic [127:0] m;
      bit neg;
      longint ma, mb;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      m = (128'(ma) * 128'(mb) + 128'(32768)) >> 16;
      if (neg) return (m >= 128'(64'd2147483648)) ? SMIN : -longint'(m);
      return (m > 128'(SMAX)) ? SMAX : longint'(m);
    endfunction

    function longint fx_div(longint num, longint den);
      logic [127:0] q;
      longint mn;
      mn = num < 0 ? -num : num;
      q = (128'(mn) << 16) / 128'(den);
      if (num < 0) return (q >= 128'(64'd2147483648)) ? SMIN : -longint'(q);
      return (q > 128'(SMAX)) ? SMAX : longint'(q);
    endfunction

    function void set_reg(logic [1:0] idx, longint v);
      case (idx)
        kcvf_pkg::REG_Q_POS:   q_pos = v & 16'hffff;
        kcvf_pkg::REG_Q_VEL:   q_vel = v & 16'hffff;
        kcvf_pkg::REG_R_MEAS:  r_meas = v & 31'h7fffffff;
        kcvf_pkg::REG_HORIZON: horizon = v & 5'h1f;
      endcase
    endfunction

    function void note_sample(logic signed [31:0] z_in, logic last);
      longint z, xp, vp, p00, p01, p10, p11, s, k0, k1, y, fp;
      int h;
      estimate_t e;
      z = z_in;
      if (!seeded) begin
        pos = z; vel = 0; cpp = UNIT; cpv = 0; cvp = 0; cvv = UNIT; seeded = 1;
      end
      xp = clip(pos + vel);
      vp = vel;
      p00 = clip(cpp + cpv + cvp + cvv + q_pos);
      p01 = clip(cpv + cvv);
      p10 = clip(cvp + cvv);
      p11 = clip(cvv + q_vel);
      s = clip(p00 + r_meas);
      if (s > 0) begin
        k0 = fx_div(p00, s); k1 = fx_div(p10, s);
      end else begin
        k0 = 0; k1 = 0;
      end
      y = clip(z - xp);
      pos = clip(xp + fx_mul(k0, y));
      vel = clip(vp + fx_mul(k1, y));
      cpp = fx_mul(clip(UNIT - k0), p00);
      cpv = fx_mul(clip(UNIT - k0), p01);
      cvp = clip(p10 - fx_mul(k1, p00));
      cvv = clip(p11 - fx_mul(k1, p01));
      h = last ? int'(horizon) : 0;
      if (h > kcvf_pkg::MAX_H) h = kcvf_pkg::MAX_H;
      e.value = pos[31:0]; e.kind = 1'b0; e.run_end = (h == 0);
      pending = {pending, e};
      if (last) begin
        fp = pos;
        for (int i = 0; i < h; i++) begin
          fp = clip(fp + vel);
          e.value = fp[31:0]; e.kind = 1'b1; e.run_end = (i == h - 1);
          pending = {pending, e};
        end
        seeded = 0;
        series++;
      end
    endfunction

    function void check_word(logic signed [31:0] v, logic k, logic re);
      estimate_t e;
      words++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word value=%0d kind=%0b run_end=%0b", $time, v, k, re);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) begin
        $display("%0t: value expected %0d actual %0d", $time, e.value, v);
        errors++;
      end
      if (k !== e.kind) begin
        $display("%0t: kind expected %0b actual %0b", $time, e.kind, k);
        errors++;
      end
      if (re !== e.run_end) begin
        $display("%0t: run_end expected %0b actual %0b", $time, e.run_end, re);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = kcvf_pkg::REG_Q_POS;
  logic [kcvf_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic signed [31:0] measurement = '0;
  logic last_sample = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] value;
  logic kind, run_end;

  filter_scoreboard sb = new();
  longint cycles = 0;
  int sent = 0;

  kalman_constant_velocity_filter_unit dut (.*);

  initial forever #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst && out_valid && !out_stall) sb.check_word(value, kind, run_end);
    if (!rst && in_valid && !in_stall) sb.note_sample(measurement, last_sample);
  end

  // receiver stalls; quiet stretches between bursts
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) < 2) repeat ($urandom_range(50, 150)) @(negedge clk);
      else begin
        g = gap_len();
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send(logic signed [31:0] z, logic last);
    int g;
    g = gap_len();
    repeat (g + 1) @(negedge clk);
    in_valid <= 1'b1;
    measurement <= z;
    last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    sent++;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= (kcvf_pkg::CFG_W)'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, longint'(v));
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_meas();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    if (r < 8) return $urandom();
    return r == 8 ? 32'sh7fffffff : 32'sh80000000;
  endfunction

  initial begin
    int len;
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: defaults, extremes, single-sample series, zero horizon
    send(32'sh00010000, 1'b0); send(32'sh00020000, 1'b0); send(32'sh00030000, 1'b1);
    send(32'sh7fffffff, 1'b1);
    send(32'sh80000000, 1'b0); send(32'sh7fffffff, 1'b0); send(32'sh80000000, 1'b1);
    send(32'sh00000000, 1'b0); send(32'shffffffff, 1'b1);
    drain();
    write_reg(kcvf_pkg::REG_HORIZON, 31);
    write_reg(kcvf_pkg::REG_R_MEAS, 32'h7fffffff);
    write_reg(kcvf_pkg::REG_Q_POS, 32'hffff);
    write_reg(kcvf_pkg::REG_Q_VEL, 32'hffff);
    send(32'sh00500000, 1'b0); send(32'sh00600000, 1'b0); send(32'sh55555555, 1'b0);
    send(32'sh2aaaaaaa, 1'b1);
    drain();
    write_reg(kcvf_pkg::REG_HORIZON, 0);
    write_reg(kcvf_pkg::REG_R_MEAS, 1);
    write_reg(kcvf_pkg::REG_Q_POS, 0);
    write_reg(kcvf_pkg::REG_Q_VEL, 0);
    send(32'sh00100000, 1'b0); send(32'sh00300000, 1'b0); send(32'sh7fff0000, 1'b1);
    send(32'sh80010000, 1'b0); send(32'sh12345678, 1'b1);
    drain();
    write_reg(kcvf_pkg::REG_HORIZON, 16);
    write_reg(kcvf_pkg::REG_R_MEAS, 6554);
    write_reg(kcvf_pkg::REG_Q_POS, 655);
    write_reg(kcvf_pkg::REG_Q_VEL, 655);
    // random series in phases with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      for (int n = 0; n < 80; ) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len && n < 80; i++, n++) send(rand_meas(), i == len - 1);
      end
      drain();
      write_reg(kcvf_pkg::REG_Q_POS, $urandom_range(0, 32'hffff));
      write_reg(kcvf_pkg::REG_Q_VEL, $urandom_range(0, 32'hffff));
      write_reg(kcvf_pkg::REG_R_MEAS,
                ph[0] ? $urandom_range(1, 32'h7fffffff) : $urandom_range(1, 200000));
      write_reg(kcvf_pkg::REG_HORIZON, $urandom_range(0, 31));
    end
    drain();
    $display("Sent %0d measurements in %0d series; checked %0d result words.",
             sent, sb.series, sb.words);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
